/* rtl/core/ssm_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted sequence merge package
// Shared constants, command codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package ssm_pkg;

	localparam int SEQ_DEPTH = 32;
	localparam int CNT_W     = $clog2(SEQ_DEPTH + 1);
	localparam int ADDR_W    = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
	localparam int DATA_W    = 32;

	typedef enum logic [1:0] {
		CMD_APPEND_FIRST  = 2'd0,
		CMD_APPEND_SECOND = 2'd1,
		CMD_MERGE         = 2'd2,
		CMD_NONE          = 2'd3
	} ssm_command_t;

	typedef struct packed {
		logic append_first;
		logic append_second;
		logic clear_flag;
		logic step;
	} ssm_cmd_t;

	typedef struct packed {
		logic both_empty;
		logic out_free;
		logic last_step;
	} ssm_status_t;

endpackage

/* rtl/core/ssm_ram.sv */
// ----------------------------------------------------------------------------
// Sorted sequence merge store RAM
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
module ssm_ram #(
	parameter int DEPTH  = 32,
	parameter int WIDTH  = 32,
	parameter int ADDR_W = 5
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/ssm_datapath.sv */
// ----------------------------------------------------------------------------
// Sorted sequence merge datapath
// Holds both stores, their fill counts, the read pointers, the overflow flag
// and the output register; performs one head comparison per merge step.
// ----------------------------------------------------------------------------
module ssm_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ssm_pkg::ssm_cmd_t          cmd,
	output ssm_pkg::ssm_status_t       status,
	input  logic signed [31:0]         value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [31:0]         merged_value,
	output logic                       from_second,
	output logic                       last,
	output logic                       overflowed
);
	import ssm_pkg::*;

	logic [CNT_W-1:0]  cnt_a_q, cnt_b_q, ptr_a_q, ptr_b_q;
	logic [CNT_W-1:0]  ptr_a_d, ptr_b_d, ptr_a_inc, ptr_b_inc;
	logic              flag_q;
	logic              full_a, full_b, we_a, we_b;
	logic [DATA_W-1:0] head_a, head_b;
	logic              take_first, last_step;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_value_q;
	logic              out_src_q, out_last_q, out_ovf_q;

	assign full_a = (cnt_a_q == CNT_W'(SEQ_DEPTH));
	assign full_b = (cnt_b_q == CNT_W'(SEQ_DEPTH));
	assign we_a   = cmd.append_first && !full_a;
	assign we_b   = cmd.append_second && !full_b;

	always_comb begin
		if (ptr_a_q == cnt_a_q) begin
			take_first = 1'b0;
		end else if (ptr_b_q == cnt_b_q) begin
			take_first = 1'b1;
		end else begin
			take_first = ($signed(head_a) <= $signed(head_b));
		end
	end

	assign ptr_a_inc = ptr_a_q + CNT_W'(take_first);
	assign ptr_b_inc = ptr_b_q + CNT_W'(!take_first);
	assign last_step = (ptr_a_inc == cnt_a_q) && (ptr_b_inc == cnt_b_q);

	always_comb begin
		ptr_a_d = ptr_a_q;
		ptr_b_d = ptr_b_q;
		if (cmd.step) begin
			if (last_step) begin
				ptr_a_d = '0;
				ptr_b_d = '0;
			end else begin
				ptr_a_d = ptr_a_inc;
				ptr_b_d = ptr_b_inc;
			end
		end
	end

	ssm_ram #(.DEPTH(SEQ_DEPTH), .WIDTH(DATA_W), .ADDR_W(ADDR_W)) u_store_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (cnt_a_q[ADDR_W-1:0]),
		.wdata (value),
		.raddr (ptr_a_d[ADDR_W-1:0]),
		.rdata (head_a)
	);

	ssm_ram #(.DEPTH(SEQ_DEPTH), .WIDTH(DATA_W), .ADDR_W(ADDR_W)) u_store_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (cnt_b_q[ADDR_W-1:0]),
		.wdata (value),
		.raddr (ptr_b_d[ADDR_W-1:0]),
		.rdata (head_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_a_q     <= '0;
			cnt_b_q     <= '0;
			ptr_a_q     <= '0;
			ptr_b_q     <= '0;
			flag_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			ptr_a_q <= ptr_a_d;
			ptr_b_q <= ptr_b_d;
			if (we_a) begin
				cnt_a_q <= cnt_a_q + CNT_W'(1);
			end
			if (we_b) begin
				cnt_b_q <= cnt_b_q + CNT_W'(1);
			end
			if ((cmd.append_first && full_a) || (cmd.append_second && full_b)) begin
				flag_q <= 1'b1;
			end
			if (cmd.clear_flag || (cmd.step && last_step)) begin
				flag_q <= 1'b0;
			end
			if (cmd.step && last_step) begin
				cnt_a_q <= '0;
				cnt_b_q <= '0;
			end
			if (cmd.step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			out_value_q <= take_first ? head_a : head_b;
			out_src_q   <= !take_first;
			out_last_q  <= last_step;
			out_ovf_q   <= flag_q;
		end
	end

	assign status.both_empty = (cnt_a_q == '0) && (cnt_b_q == '0);
	assign status.out_free   = !out_valid_q || out_ready;
	assign status.last_step  = last_step;

	assign out_valid    = out_valid_q;
	assign merged_value = out_value_q;
	assign from_second  = out_src_q;
	assign last         = out_last_q;
	assign overflowed   = out_ovf_q;

endmodule

/* rtl/core/ssm_ctrl.sv */
// ----------------------------------------------------------------------------
// Sorted sequence merge controller
// Accepts transactions while idle and sequences the merge steps.
// ----------------------------------------------------------------------------
module ssm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           command,
	input  ssm_pkg::ssm_status_t status,
	output ssm_pkg::ssm_cmd_t    cmd
);
	import ssm_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_MERGE = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d           = state_q;
		cmd.append_first  = 1'b0;
		cmd.append_second = 1'b0;
		cmd.clear_flag    = 1'b0;
		cmd.step          = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (command)
						CMD_APPEND_FIRST:  cmd.append_first = 1'b1;
						CMD_APPEND_SECOND: cmd.append_second = 1'b1;
						CMD_MERGE: begin
							if (status.both_empty) begin
								cmd.clear_flag = 1'b1;
							end else begin
								state_d = ST_MERGE;
							end
						end
						default: ;
					endcase
				end
			end
			ST_MERGE: begin
				if (status.out_free) begin
					cmd.step = 1'b1;
					if (status.last_step) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/core/sorted_sequence_merge.sv */
// ----------------------------------------------------------------------------
// Sorted sequence merge
// Two-way merge of two ascending signed sequences held in on-chip stores.
// ----------------------------------------------------------------------------
// Append transactions are taken one per cycle while idle and never
// produce a result. A merge with values stored enters the merge state,
// where each step loads the output register, one result per cycle while
// the output is not stalled; input is held off until the last step.
// Reset clears the fill counts, read pointers, overflow flag and output
// valid; the store contents are not cleared.
module sorted_sequence_merge (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         command,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] merged_value,
	output logic               from_second,
	output logic               last,
	output logic               overflowed
);
	import ssm_pkg::*;

	ssm_cmd_t    cmd;
	ssm_status_t status;

	ssm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.status   (status),
		.cmd      (cmd)
	);

	ssm_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.value        (value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.merged_value (merged_value),
		.from_second  (from_second),
		.last         (last),
		.overflowed   (overflowed)
	);

endmodule

/* rtl/core/ssm_checker.sv */
// ----------------------------------------------------------------------------
// Sorted sequence merge port checker
// Concurrent assertions on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
module ssm_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [1:0]         command,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] merged_value,
	input logic               last
);
	import ssm_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(merged_value) && $stable(last))
		else $error("Output transaction changed before it was taken.");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid)
		else $error("Merge run broken before its last result.");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && !out_valid && !(in_valid && command == CMD_MERGE) |=> !out_valid)
		else $error("Result produced without a merge.");

endmodule

bind sorted_sequence_merge ssm_checker u_ssm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.command      (command),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.merged_value (merged_value),
	.last         (last)
);
